// ===== design/ffpa_pkg.sv =====
// ---------------------------------------------------------------------------
// ffpa_pkg: shared types and constants of the first-fit pool allocator
// Payload structs of both channels, free-list entry and control types, and
// the fixed page and pool geometry.
// ---------------------------------------------------------------------------
package ffpa_pkg;

   // Field widths
   localparam int SIZE_W = 32;
   localparam int OFF_W  = 28;
   localparam int LEN_W  = 29;
   localparam int GEN_W  = 16;

   // Pool geometry (page size is a power of two)
   localparam int unsigned PAGE_BYTES = 4096;
   localparam int unsigned POOL_BYTES = 268435456;

   // Operation codes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Status codes
   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_TOO_BIG   = 2'd1;
   localparam logic [1:0] ST_RELEASED  = 2'd2;
   localparam logic [1:0] ST_DROPPED   = 2'd3;

   typedef struct packed {
      logic              operation;
      logic [SIZE_W-1:0] request_size;
      logic [OFF_W-1:0]  release_offset;
      logic [LEN_W-1:0]  release_length;
      logic [GEN_W-1:0]  release_generation;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] slot_offset;
      logic [LEN_W-1:0] slot_length;
      logic [GEN_W-1:0] slot_generation;
      logic             opened_pool;
   } rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] len;
   } entry_type;

   // Free-list control from the sequencer
   typedef struct packed {
      logic clear;    // empty the list
      logic push;     // append push entry at the tail
      logic pop;      // drop the tail entry
      logic rd_last;  // read the tail entry instead of the read index
      logic wr_at;    // move the last read entry to the write index
   } list_cmd_type;

endpackage

// ===== design/ffpa_free_list.sv =====
// ---------------------------------------------------------------------------
// ffpa_free_list: free-list storage of the pool allocator
// One memory of offset/length entries with a single write port and one
// registered read port, plus the fill count that bounds the valid entries.
// ---------------------------------------------------------------------------
module ffpa_free_list #(
   parameter int FREE_SLOTS = 512,
   localparam int IW = $clog2(FREE_SLOTS),
   localparam int CW = $clog2(FREE_SLOTS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ffpa_pkg::list_cmd_type cmd,
   input  logic [IW-1:0]        rd_idx,
   input  logic [IW-1:0]        wr_idx,
   input  ffpa_pkg::entry_type  push_entry,
   output logic [CW-1:0]        count,
   output ffpa_pkg::entry_type  rd_entry
);

   ffpa_pkg::entry_type mem [FREE_SLOTS];
   ffpa_pkg::entry_type rd_entry_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       count_dec;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic [IW-1:0]       rd_addr;
   ffpa_pkg::entry_type wr_data;

   assign count_dec = count_ff - CW'(1);

   // Select write port: tail push or swap move of the last read entry
   always_comb begin
      wr_en   = cmd.push | cmd.wr_at;
      wr_addr = cmd.push ? count_ff[IW-1:0] : wr_idx;
      wr_data = cmd.push ? push_entry : rd_entry_ff;
      rd_addr = cmd.rd_last ? count_dec[IW-1:0] : rd_idx;
   end

   // Write and read the memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   // Track fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count    = count_ff;
   assign rd_entry = rd_entry_ff;

endmodule

// ===== design/first_fit_pool_allocator_top.sv =====
// ---------------------------------------------------------------------------
// first_fit_pool_allocator_top: first-fit page slot allocator
// Request channel (req_) takes allocate or release beats; response channel
// (rsp_) returns exactly one beat per request, in order.
// An allocate rounds its size to whole pages and scans the free list one
// entry per cycle for the first entry that fits, then swap-removes it and
// pushes back any tail remainder; with no fit it carves from the bump cursor,
// opening a new pool generation when the cursor would pass the pool end.
// A nonzero current-generation release is pushed if the free list has room.
// A release or too-big allocate goes from the decode state straight to the done
// state that loads the response register; an allocate first scans the free
// list, through the single read port of the free-list memory, one entry per
// cycle up to the fill count. One request is in work at a time; req_stall
// is high from accept until the response is loaded, and the next request is
// taken the cycle after. The response register holds a finished beat while
// rsp_stall is high, and a new request may be accepted meanwhile; it waits
// only if it finishes first.
// Reset (synchronous) empties the free list, clears the cursor and
// generation, and marks no pool open; the list memory needs no clearing.
// ---------------------------------------------------------------------------
module first_fit_pool_allocator_top #(
   parameter int FREE_SLOTS = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffpa_pkg::rsp_type rsp_data
);

   localparam int IW    = $clog2(FREE_SLOTS);
   localparam int CW    = $clog2(FREE_SLOTS + 1);
   localparam int OFF_W = ffpa_pkg::OFF_W;
   localparam int LEN_W = ffpa_pkg::LEN_W;
   localparam int GEN_W = ffpa_pkg::GEN_W;
   localparam int RW    = ffpa_pkg::SIZE_W + 1;

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_SWAP_RD = 3'd3;
   localparam logic [2:0] S_SWAP_WR = 3'd4;
   localparam logic [2:0] S_PUSH    = 3'd5;
   localparam logic [2:0] S_BUMP    = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic             op_ff, op_in;
   logic             big_ff, big_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [OFF_W-1:0] roff_ff, roff_in;
   logic [LEN_W-1:0] rlen_ff, rlen_in;
   logic [GEN_W-1:0] rgen_ff, rgen_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic [LEN_W-1:0] cursor_ff, cursor_in;
   logic             open_ff, open_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IW-1:0]    pidx_ff, pidx_in;
   logic [IW-1:0]    hit_idx_ff, hit_idx_in;
   logic [OFF_W-1:0] hit_off_ff, hit_off_in;
   logic [LEN_W-1:0] hit_len_ff, hit_len_in;
   logic [1:0]       status_ff, status_in;
   logic [OFF_W-1:0] res_off_ff, res_off_in;
   logic             opened_ff, opened_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ffpa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                   rsp_load;
   logic [RW-1:0]          rounded;
   logic [RW-1:0]          page_len;
   logic [LEN_W:0]         bump_sum;
   ffpa_pkg::rsp_type      rsp_build;
   ffpa_pkg::list_cmd_type cmd;
   logic [IW-1:0]          rd_idx;
   logic [IW-1:0]          wr_idx;
   ffpa_pkg::entry_type    push_entry;
   logic [CW-1:0]          list_count;
   ffpa_pkg::entry_type    rd_entry;

   ffpa_free_list #(
      .FREE_SLOTS(FREE_SLOTS)
   ) u_free_list (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_idx     (rd_idx),
      .wr_idx     (wr_idx),
      .push_entry (push_entry),
      .count      (list_count),
      .rd_entry   (rd_entry)
   );

   // Round request size up to whole pages; zero becomes one page
   always_comb begin
      rounded  = ({1'b0, req_data.request_size} + RW'(ffpa_pkg::PAGE_BYTES - 1))
                 & ~RW'(ffpa_pkg::PAGE_BYTES - 1);
      page_len = (rounded == '0) ? RW'(ffpa_pkg::PAGE_BYTES) : rounded;
      bump_sum = {1'b0, cursor_ff} + {1'b0, len_ff};
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      big_in     = big_ff;
      len_in     = len_ff;
      roff_in    = roff_ff;
      rlen_in    = rlen_ff;
      rgen_in    = rgen_ff;
      gen_in     = gen_ff;
      cursor_in  = cursor_ff;
      open_in    = open_ff;
      issue_in   = issue_ff;
      pend_in    = pend_ff;
      pidx_in    = pidx_ff;
      hit_idx_in = hit_idx_ff;
      hit_off_in = hit_off_ff;
      hit_len_in = hit_len_ff;
      status_in  = status_ff;
      res_off_in = res_off_ff;
      opened_in  = opened_ff;
      rsp_load   = 1'b0;
      cmd        = '0;
      rd_idx     = issue_ff[IW-1:0];
      wr_idx     = hit_idx_ff;
      push_entry = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_data.operation;
               big_in     = page_len > RW'(ffpa_pkg::POOL_BYTES);
               len_in     = page_len[LEN_W-1:0];
               roff_in    = req_data.release_offset;
               rlen_in    = req_data.release_length;
               rgen_in    = req_data.release_generation;
               opened_in  = 1'b0;
               res_off_in = '0;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (op_ff == ffpa_pkg::OP_RELEASE) begin
               // Push a nonzero current-generation slot if the list has room
               if (rgen_ff == gen_ff && rlen_ff != '0 && list_count < CW'(FREE_SLOTS)) begin
                  cmd.push       = 1'b1;
                  push_entry.off = roff_ff;
                  push_entry.len = rlen_ff;
                  status_in      = ffpa_pkg::ST_RELEASED;
               end else begin
                  status_in = ffpa_pkg::ST_DROPPED;
               end
               state_in = S_DONE;
            end else if (big_ff) begin
               status_in = ffpa_pkg::ST_TOO_BIG;
               state_in  = S_DONE;
            end else begin
               status_in = ffpa_pkg::ST_ALLOCATED;
               issue_in  = '0;
               pend_in   = 1'b0;
               if (!open_ff) begin
                  // Open the first pool: list is empty, go straight to bump
                  cmd.clear = 1'b1;
                  gen_in    = gen_ff + GEN_W'(1);
                  cursor_in = '0;
                  open_in   = 1'b1;
                  opened_in = 1'b1;
                  state_in  = S_BUMP;
               end else if (list_count == '0) begin
                  state_in = S_BUMP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Compare last read entry, issue next read, or give up
            if (pend_ff && rd_entry.len >= len_ff) begin
               hit_idx_in = pidx_ff;
               hit_off_in = rd_entry.off;
               hit_len_in = rd_entry.len;
               pend_in    = 1'b0;
               state_in   = S_SWAP_RD;
            end else if (issue_ff < list_count) begin
               pend_in  = 1'b1;
               pidx_in  = issue_ff[IW-1:0];
               issue_in = issue_ff + CW'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = S_BUMP;
            end
         end
         S_SWAP_RD: begin
            // Read tail entry and drop it from the count
            cmd.pop     = 1'b1;
            cmd.rd_last = 1'b1;
            state_in    = S_SWAP_WR;
         end
         S_SWAP_WR: begin
            // Move tail entry into the hole
            cmd.wr_at  = 1'b1;
            res_off_in = hit_off_ff;
            state_in   = (hit_len_ff != len_ff) ? S_PUSH : S_DONE;
         end
         S_PUSH: begin
            // Push back the tail remainder
            cmd.push       = 1'b1;
            push_entry.off = hit_off_ff + len_ff[OFF_W-1:0];
            push_entry.len = hit_len_ff - len_ff;
            state_in       = S_DONE;
         end
         S_BUMP: begin
            if (bump_sum > (LEN_W + 1)'(ffpa_pkg::POOL_BYTES)) begin
               // Cursor would pass the pool end: open a new pool
               cmd.clear  = 1'b1;
               gen_in     = gen_ff + GEN_W'(1);
               opened_in  = 1'b1;
               res_off_in = '0;
               cursor_in  = len_ff;
            end else begin
               res_off_in = cursor_ff[OFF_W-1:0];
               cursor_in  = bump_sum[LEN_W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hand the result to the response register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Build response beat; only allocations carry slot fields
   always_comb begin
      rsp_build        = '0;
      rsp_build.status = status_ff;
      if (status_ff == ffpa_pkg::ST_ALLOCATED) begin
         rsp_build.slot_offset     = res_off_ff;
         rsp_build.slot_length     = len_ff;
         rsp_build.slot_generation = gen_ff;
         rsp_build.opened_pool     = opened_ff;
      end
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_load ? rsp_build : rsp_data_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_ff       <= '0;
         cursor_ff    <= '0;
         open_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         cursor_ff    <= cursor_in;
         open_ff      <= open_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      big_ff      <= big_in;
      len_ff      <= len_in;
      roff_ff     <= roff_in;
      rlen_ff     <= rlen_in;
      rgen_ff     <= rgen_in;
      issue_ff    <= issue_in;
      pidx_ff     <= pidx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_off_ff  <= hit_off_in;
      hit_len_ff  <= hit_len_in;
      status_ff   <= status_in;
      res_off_ff  <= res_off_in;
      opened_ff   <= opened_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
